// ===== src/srph_pkg.sv =====
// ----------------------------------------------------------------------------
// srph_pkg
// Shared widths, codes and defaults for the sparse random projection hash.
// ----------------------------------------------------------------------------
`default_nettype none

package srph_pkg;

   // fixed payload widths
   localparam int DIM_W     = 10;
   localparam int HASH_W    = 4;
   localparam int COEF_W    = 2;
   localparam int ELEM_W    = 16;
   localparam int SIG_W     = 16;
   // wide enough to compare any dimension against the largest table depth
   localparam int DIM_EXT_W = 17;

   // parameter defaults
   localparam int NUM_HASHES_DEF = 16;
   localparam int DIM_MAX_DEF    = 1024;
   localparam int VALUE_BITS_DEF = 16;

   // item kinds
   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_DATA = 1'b1;

   // stored coefficient codes: bit 0 = active, bit 1 = subtract
   localparam logic [1:0] COEF_ZERO = 2'b00;
   localparam logic [1:0] COEF_POS  = 2'b01;
   localparam logic [1:0] COEF_NEG  = 2'b11;

   // control travelling with a data word into the accumulate stage
   typedef struct packed {
      logic valid;
      logic last;
      logic in_range;
   } stage_ctl_type;

endpackage

`default_nettype wire

// ===== src/srph_if.sv =====
// ----------------------------------------------------------------------------
// srph request / response channels
// Valid/ready channels carrying input words and signature words.
// ----------------------------------------------------------------------------
`default_nettype none

interface srph_req_if
   import srph_pkg::*;
   ;
   logic                     valid;
   logic                     ready;
   logic                     mode;
   logic [DIM_W-1:0]         dim_index;
   logic [HASH_W-1:0]        hash_index;
   logic signed [COEF_W-1:0] coef;
   logic signed [ELEM_W-1:0] element_value;
   logic                     last_element;

   modport source (output valid, mode, dim_index, hash_index, coef, element_value,
                   last_element, input ready);
   modport sink   (input valid, mode, dim_index, hash_index, coef, element_value,
                   last_element, output ready);
endinterface

interface srph_rsp_if
   import srph_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [SIG_W-1:0] signature;

   modport source (output valid, signature, input ready);
   modport sink   (input valid, signature, output ready);
endinterface

`default_nettype wire

// ===== src/srph_coef_mem.sv =====
// ----------------------------------------------------------------------------
// srph_coef_mem
// Projection table: one 2-bit column memory per hash, registered row read,
// and a zeroing sweep over every row after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module srph_coef_mem
   import srph_pkg::*;
#(
   parameter int NUM_HASHES = NUM_HASHES_DEF,
   parameter int DIM_MAX    = DIM_MAX_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            wr_en,
   input  wire logic [((DIM_MAX > 1) ? $clog2(DIM_MAX) : 1)-1:0] wr_addr,
   input  wire logic [HASH_W-1:0]               wr_hash,
   input  wire logic [1:0]                      wr_code,
   input  wire logic                            rd_en,
   input  wire logic [((DIM_MAX > 1) ? $clog2(DIM_MAX) : 1)-1:0] rd_addr,
   output logic [NUM_HASHES-1:0][1:0]           rd_row,
   output logic                                 clearing
);

   localparam int ADDR_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

   logic              clear_ff, clear_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              clr_done;

   assign clr_done = (clr_addr_ff == ADDR_W'(DIM_MAX - 1));
   assign clearing = clear_ff;

   always_comb begin
      clear_in    = clear_ff & ~clr_done;
      clr_addr_in = clear_ff ? clr_addr_ff + 1'b1 : clr_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff    <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clear_ff    <= clear_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   for (genvar g = 0; g < NUM_HASHES; g++) begin : g_col
      logic [1:0] col_mem [DIM_MAX];
      logic [1:0] rd_ff;
      logic       col_we;

      assign col_we    = wr_en & (int'(wr_hash) == g);
      assign rd_row[g] = rd_ff;

      always_ff @(posedge clock) begin
         if (clear_ff) begin
            col_mem[clr_addr_ff] <= COEF_ZERO;
         end else if (col_we) begin
            col_mem[wr_addr] <= wr_code;
         end
         if (rd_en) begin
            rd_ff <= col_mem[rd_addr];
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/srph_accum.sv =====
// ----------------------------------------------------------------------------
// srph_accum
// Per-hash accumulators and the signature output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srph_accum
   import srph_pkg::*;
#(
   parameter int NUM_HASHES = NUM_HASHES_DEF,
   parameter int DIM_MAX    = DIM_MAX_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire stage_ctl_type                ctl,
   input  wire logic signed [VALUE_BITS-1:0] value,
   input  wire logic [NUM_HASHES-1:0][1:0]   row,
   output logic                              stall,
   srph_rsp_if.source                        rsp
);

   localparam int ADDR_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam int ACC_W  = VALUE_BITS + ADDR_W + 1;

   logic signed [ACC_W-1:0] val_ext;
   logic signed [ACC_W-1:0] acc_ff [NUM_HASHES];
   logic signed [ACC_W-1:0] acc_in [NUM_HASHES];
   logic signed [ACC_W-1:0] sum    [NUM_HASHES];
   logic [SIG_W-1:0]        sig_ff, sig_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    advance;

   assign val_ext = {{(ACC_W - VALUE_BITS){value[VALUE_BITS-1]}}, value};

   // a last word may only retire once the output register has room
   assign stall   = ctl.valid & ctl.last & rsp_valid_ff & ~rsp.ready;
   assign advance = ctl.valid & ~stall;

   for (genvar g = 0; g < NUM_HASHES; g++) begin : g_acc
      always_comb begin
         sum[g] = acc_ff[g];
         if (ctl.in_range) begin
            case (row[g])
               COEF_POS: sum[g] = acc_ff[g] + val_ext;
               COEF_NEG: sum[g] = acc_ff[g] - val_ext;
               default:  sum[g] = acc_ff[g];
            endcase
         end
      end

      always_comb begin
         acc_in[g] = acc_ff[g];
         if (advance) begin
            acc_in[g] = ctl.last ? '0 : sum[g];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            acc_ff[g] <= '0;
         end else begin
            acc_ff[g] <= acc_in[g];
         end
      end
   end

   // only hashes that fit the signature word report
   logic [SIG_W-1:0] sig_next;
   for (genvar b = 0; b < SIG_W; b++) begin : g_sig
      if (b < NUM_HASHES) begin : g_used
         assign sig_next[b] = sum[b][ACC_W-1];
      end else begin : g_unused
         assign sig_next[b] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp.ready;
      sig_in       = sig_ff;
      if (advance && ctl.last) begin
         rsp_valid_in = 1'b1;
         sig_in       = sig_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      sig_ff <= sig_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.signature = sig_ff;

endmodule

`default_nettype wire

// ===== src/sparse_random_projection_hash_top.sv =====
// ----------------------------------------------------------------------------
// sparse_random_projection_hash_top
// Signed random projection hash over a loadable +1/-1/0 projection table.
//
// Channels: req_bus takes words; mode 0 loads one coefficient of the table
// (row dim_index, hash hash_index), mode 1 is a vector element. rsp_bus
// carries one signature word per vector, sent on the element marked last.
// Bit h of the signature is set when the sum for hash h is negative.
// Throughput: one word per cycle while req_bus.ready is high, limited by the
// single read port of the table (one row per cycle). A load can be followed
// at once by an element reading the same row.
// Path: a last element's signature is formed after the row read and element
// registers and shows on rsp_bus from the signature register; while that
// register is still full, the element waits in the element registers.
// Reset: the accumulators clear at once; the table is then swept to zero,
// one row per cycle over all DIM_MAX rows, with req_bus.ready low.
// Stall: the signature register holds until taken; elements keep flowing
// until a further last element finds it still full, then ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_random_projection_hash_top
   import srph_pkg::*;
#(
   parameter int NUM_HASHES = NUM_HASHES_DEF,
   parameter int DIM_MAX    = DIM_MAX_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   srph_req_if.sink   req_bus,
   srph_rsp_if.source rsp_bus
);

   localparam int ADDR_W = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;

   logic                   clearing;
   logic                   stall;
   logic                   accept;
   logic                   load_we;
   logic                   data_rd;
   logic [DIM_EXT_W-1:0]   dim_ext;
   logic                   dim_ok;
   logic [ADDR_W-1:0]      addr;
   logic [1:0]             wr_code;
   logic signed [VALUE_BITS-1:0] value_cur;
   logic [NUM_HASHES-1:0][1:0]   row;

   stage_ctl_type                ctl_ff, ctl_in;
   logic signed [VALUE_BITS-1:0] value_ff, value_in;

   assign req_bus.ready = ~clearing & ~stall;
   assign accept        = req_bus.valid & req_bus.ready;

   assign dim_ext = DIM_EXT_W'(req_bus.dim_index);
   assign dim_ok  = (dim_ext < DIM_EXT_W'(DIM_MAX));
   assign addr    = dim_ext[ADDR_W-1:0];

   assign load_we = accept & (req_bus.mode == MODE_LOAD) & dim_ok
                  & (int'(req_bus.hash_index) < NUM_HASHES);
   assign data_rd = accept & (req_bus.mode == MODE_DATA);

   // coefficient pattern -2 counts as -1
   assign wr_code = req_bus.coef[1] ? COEF_NEG : (req_bus.coef[0] ? COEF_POS : COEF_ZERO);

   // element value cut to VALUE_BITS, or zero-extended when VALUE_BITS is wider
   if (VALUE_BITS <= ELEM_W) begin : g_val_narrow
      assign value_cur = req_bus.element_value[VALUE_BITS-1:0];
   end else begin : g_val_wide
      assign value_cur = {{(VALUE_BITS - ELEM_W){1'b0}}, req_bus.element_value};
   end

   always_comb begin
      ctl_in   = ctl_ff;
      value_in = value_ff;
      if (req_bus.ready) begin
         ctl_in.valid    = data_rd;
         ctl_in.last     = req_bus.last_element;
         ctl_in.in_range = dim_ok;
         value_in        = value_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      value_ff <= value_in;
   end

   srph_coef_mem #(
      .NUM_HASHES (NUM_HASHES),
      .DIM_MAX    (DIM_MAX)
   ) u_coef_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (load_we),
      .wr_addr  (addr),
      .wr_hash  (req_bus.hash_index),
      .wr_code  (wr_code),
      .rd_en    (data_rd),
      .rd_addr  (addr),
      .rd_row   (row),
      .clearing (clearing)
   );

   srph_accum #(
      .NUM_HASHES (NUM_HASHES),
      .DIM_MAX    (DIM_MAX),
      .VALUE_BITS (VALUE_BITS)
   ) u_accum (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl_ff),
      .value (value_ff),
      .row   (row),
      .stall (stall),
      .rsp   (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== bench/sparse_random_projection_hash_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sparse_random_projection_hash_top_tb
// Loads projection coefficients and streams dense and sparse vectors through
// the hash block. A local model of the table and the per-hash sums predicts
// every signature word, and a checker compares each one as it is taken.
// Both channels idle and stall in random bursts, and the signature side is
// held off once for a long stretch so that the block has to stall its input.
// ----------------------------------------------------------------------------

module sparse_random_projection_hash_top_tb;
   import srph_pkg::*;

   localparam int CLK_PERIOD     = 8;
   localparam int N_HASH         = NUM_HASHES_DEF;
   localparam int N_DIM          = DIM_MAX_DEF;
   localparam int ACC_W          = 27;
   localparam int POOL_SIZE      = 32;
   localparam int HOLD_OFF       = 300;
   localparam int TAIL_CYCLES    = 8;
   // reset sweep of the table plus the long hold-off, several times over
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int VALUE_MIN      = -32768;
   localparam int VALUE_MAX      = 32767;
   localparam int REPORT_MAX     = 10;

   // the other negative pattern of the two-bit coefficient
   localparam logic [COEF_W-1:0] COEF_ALT_NEG = 2'b10;

   typedef struct packed {
      logic              mode;
      logic [DIM_W-1:0]  dim;
      logic [HASH_W-1:0] hash;
      logic [COEF_W-1:0] coef;
      logic [ELEM_W-1:0] value;
      logic              last;
   } proj_word_type;

   logic clock = 1'b0;
   logic reset;

   srph_req_if req_bus();
   srph_rsp_if rsp_bus();

   sparse_random_projection_hash_top #(
      .NUM_HASHES(N_HASH),
      .DIM_MAX   (N_DIM),
      .VALUE_BITS(VALUE_BITS_DEF)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // local copy of the projection table and the running sums
   logic [COEF_W-1:0]       proj_table [N_DIM][N_HASH];
   logic signed [ACC_W-1:0] hash_acc [N_HASH];
   logic [SIG_W-1:0]        sig_expected [$];

   int dim_pool [$];
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int hold_rsp_req  = 0;
   int words_sent    = 0;
   int loads_sent    = 0;
   int elems_sent    = 0;
   int sigs_checked  = 0;
   int error_count   = 0;

   function automatic void note_error(input string what, input logic [SIG_W-1:0] want,
                                      input logic [SIG_W-1:0] got);
      error_count++;
      if (error_count <= REPORT_MAX)
         $display("%0t  %s: expected %h, got %h", $time, what, want, got);
   endfunction

   // applies one word to the local table/sums; returns 1 when a signature is due
   function automatic bit project_word(input proj_word_type w, output logic [SIG_W-1:0] sig);
      sig = '0;
      if (w.mode == MODE_LOAD) begin
         if (w.hash < N_HASH && w.dim < N_DIM) begin
            case (w.coef)
               COEF_ZERO: proj_table[w.dim][w.hash] = COEF_ZERO;
               COEF_POS:  proj_table[w.dim][w.hash] = COEF_POS;
               default:   proj_table[w.dim][w.hash] = COEF_NEG;  // both negative patterns
            endcase
         end
         return 1'b0;
      end
      if (w.dim < N_DIM) begin
         for (int h = 0; h < N_HASH; h++) begin
            if (proj_table[w.dim][h] == COEF_POS)
               hash_acc[h] += $signed(w.value);
            else if (proj_table[w.dim][h] == COEF_NEG)
               hash_acc[h] -= $signed(w.value);
         end
      end
      if (!w.last)
         return 1'b0;
      for (int h = 0; h < N_HASH && h < SIG_W; h++)
         sig[h] = (hash_acc[h] < 0);  // a zero sum leaves the bit clear
      for (int h = 0; h < N_HASH; h++)
         hash_acc[h] = '0;
      return 1'b1;
   endfunction

   function automatic proj_word_type load_word(input int dim, input int hash,
                                               input logic [COEF_W-1:0] coef, input bit last);
      proj_word_type w;
      w.mode  = MODE_LOAD;
      w.dim   = DIM_W'(dim);
      w.hash  = HASH_W'(hash);
      w.coef  = coef;
      w.value = ELEM_W'($urandom);  // ignored on a load
      w.last  = last;
      return w;
   endfunction

   function automatic proj_word_type elem_word(input int dim, input int value, input bit last);
      proj_word_type w;
      w.mode  = MODE_DATA;
      w.dim   = DIM_W'(dim);
      w.hash  = HASH_W'($urandom);  // ignored on an element
      w.coef  = COEF_W'($urandom);
      w.value = ELEM_W'(value);
      w.last  = last;
      return w;
   endfunction

   function automatic int pick_value();
      case ($urandom_range(15))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2:       return 0;
         3:       return -1;
         default: return int'($urandom_range(65535));
      endcase
   endfunction

   // entered and left at a falling edge; valid stays high between back-to-back words
   task automatic send_word(input proj_word_type w);
      logic [SIG_W-1:0] sig;
      if (req_gap_pct != 0 && $urandom_range(99) < req_gap_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(15, 1)) @(negedge clock);
      end
      req_bus.mode          <= w.mode;
      req_bus.dim_index     <= w.dim;
      req_bus.hash_index    <= w.hash;
      req_bus.coef          <= w.coef;
      req_bus.element_value <= w.value;
      req_bus.last_element  <= w.last;
      req_bus.valid         <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (project_word(w, sig))
         sig_expected.push_back(sig);
      words_sent++;
      if (w.mode == MODE_LOAD)
         loads_sent++;
      else
         elems_sent++;
      @(negedge clock);
   endtask

   task automatic send_random_vector(input int max_len);
      int len, kind, d, n;
      bit taken [int];
      len  = $urandom_range(max_len, 1);
      kind = $urandom_range(99);
      if (kind < 5) begin
         // dense over the whole working set, in order
         for (n = 0; n < POOL_SIZE; n++)
            send_word(elem_word(dim_pool[n], pick_value(), n == POOL_SIZE - 1));
      end else if (kind < 15) begin
         d = $urandom_range(N_DIM - len);
         for (n = 0; n < len; n++)
            send_word(elem_word(d + n, pick_value(), n == len - 1));
      end else begin
         n = 0;
         while (n < len) begin
            if (kind < 25)
               d = $urandom_range(N_DIM - 1);
            else
               d = dim_pool[$urandom_range(POOL_SIZE - 1)];
            if (!taken.exists(d)) begin
               taken[d] = 1'b1;
               n++;
               // stray table writes in the middle of a vector
               if (kind >= 85 && $urandom_range(3) == 0)
                  send_word(load_word(dim_pool[$urandom_range(POOL_SIZE - 1)],
                                      $urandom_range(N_HASH - 1), COEF_W'($urandom_range(3)),
                                      1'($urandom_range(1))));
               send_word(elem_word(d, pick_value(), n == len));
            end
         end
      end
   endtask

   task automatic test_directed_corners();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      send_word(load_word(0, 0, COEF_POS, 1'b0));
      send_word(load_word(0, 1, COEF_NEG, 1'b0));
      send_word(load_word(0, 2, COEF_ALT_NEG, 1'b0));
      send_word(load_word(0, 15, COEF_POS, 1'b0));
      send_word(elem_word(0, VALUE_MAX, 1'b1));
      // row read on the cycle straight after its load
      send_word(load_word(N_DIM - 1, 3, COEF_POS, 1'b0));
      send_word(elem_word(N_DIM - 1, VALUE_MIN, 1'b1));
      send_word(elem_word(0, VALUE_MIN, 1'b0));
      send_word(elem_word(0, VALUE_MAX, 1'b1));
      send_word(elem_word(0, 0, 1'b1));
      send_word(elem_word(0, 12345, 1'b0));
      send_word(elem_word(0, -12345, 1'b1));
      send_word(elem_word(512, -100, 1'b1));   // row never written
      send_word(load_word(0, 0, COEF_ZERO, 1'b0));
      send_word(elem_word(0, -1, 1'b1));
      // last bit on a load must not emit anything
      send_word(load_word(2, 4, COEF_NEG, 1'b1));
      send_word(elem_word(2, 1000, 1'b1));
   endtask

   task automatic test_random_table();
      bit chosen [int];
      int d;
      req_gap_pct   = 15;
      rsp_stall_pct = 25;
      while (dim_pool.size() < POOL_SIZE) begin
         d = $urandom_range(N_DIM - 1);
         if (!chosen.exists(d)) begin
            chosen[d] = 1'b1;
            dim_pool.push_back(d);
         end
      end
      repeat (340) begin
         if ($urandom_range(9) == 0)
            d = $urandom_range(N_DIM - 1);
         else
            d = dim_pool[$urandom_range(POOL_SIZE - 1)];
         send_word(load_word(d, $urandom_range(N_HASH - 1), COEF_W'($urandom_range(3)),
                             1'($urandom_range(1))));
      end
   endtask

   task automatic test_random_vectors();
      int stop;
      stop = words_sent + 560;
      while (words_sent < stop) begin
         if ($urandom_range(7) == 0) begin
            req_gap_pct   = $urandom_range(2) * 20;
            rsp_stall_pct = $urandom_range(2) * 20;
         end
         send_random_vector(($urandom_range(19) == 0) ? POOL_SIZE : 8);
      end
   endtask

   task automatic test_backpressure();
      int stop;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_rsp_req  = HOLD_OFF;
      stop = words_sent + 60;
      while (words_sent < stop)
         send_random_vector(3);
   endtask

   task automatic test_tail_no_idle();
      int stop;
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      stop = words_sent + 150;
      while (words_sent < stop)
         send_random_vector(8);
   endtask

   // signature side: random hold-off bursts, plus one long stretch on request
   initial begin
      int hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req > 0) begin
            hold_left    = hold_rsp_req;
            hold_rsp_req = 0;
         end else if (hold_left == 0 && rsp_stall_pct != 0
                      && $urandom_range(99) < rsp_stall_pct) begin
            hold_left = $urandom_range(15, 1);
         end
         rsp_bus.ready <= (hold_left == 0);
         if (hold_left > 0)
            hold_left--;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         sigs_checked++;
         if (sig_expected.size() == 0)
            note_error("signature word with none outstanding", 'x, rsp_bus.signature);
         else if (rsp_bus.signature !== sig_expected[0])
            note_error("signature mismatch", sig_expected.pop_front(), rsp_bus.signature);
         else
            void'(sig_expected.pop_front());
      end
   end

   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
             || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("timeout: no word moved for %0d cycles, %0d signatures outstanding",
               WATCHDOG_LIMIT, sig_expected.size());
      $display("sparse_random_projection_hash_top_tb failed");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.mode          = MODE_LOAD;
      req_bus.dim_index     = '0;
      req_bus.hash_index    = '0;
      req_bus.coef          = COEF_ZERO;
      req_bus.element_value = '0;
      req_bus.last_element  = 1'b0;
      for (int d = 0; d < N_DIM; d++)
         for (int h = 0; h < N_HASH; h++)
            proj_table[d][h] = COEF_ZERO;
      for (int h = 0; h < N_HASH; h++)
         hash_acc[h] = '0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_random_table();
      test_random_vectors();
      test_backpressure();
      test_tail_no_idle();

      req_bus.valid <= 1'b0;
      while (sig_expected.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d words (%0d coefficient loads, %0d elements), %0d signatures checked",
               words_sent, loads_sent, elems_sent, sigs_checked);
      $display("run: all coefficient patterns, dense and sparse vectors, %0d-cycle hold-off",
               HOLD_OFF);
      if (error_count == 0)
         $display("sparse_random_projection_hash_top_tb passed");
      else
         $display("sparse_random_projection_hash_top_tb failed");
      $finish;
   end

endmodule

// ===== sparse_random_projection_hash_top.f =====
src/srph_pkg.sv
src/srph_if.sv
src/srph_coef_mem.sv
src/srph_accum.sv
src/sparse_random_projection_hash_top.sv
bench/sparse_random_projection_hash_top_tb.sv
